[rtl/core/adaptive_tank_prime_pump_controller_unit_defines.svh]
// Assertion macros for the checker file of the pump controller (atppc_checker).
`ifndef ADAPTIVE_TANK_PRIME_PUMP_CONTROLLER_UNIT_DEFINES_SVH
`define ADAPTIVE_TANK_PRIME_PUMP_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ATPPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ATPPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/atppc_pkg.sv]
`default_nettype none

package atppc_pkg;

  // Configuration port geometry.
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // Power limits and register reset values.
  localparam logic [9:0]  POWER_MAX         = 10'd600;
  localparam logic [9:0]  STEP_RESET        = 10'd30;
  localparam logic [15:0] START_DELAY_RESET = 16'd100;
  localparam logic [15:0] STOP_DELAY_RESET  = 16'd0;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_START_DELAY = 2'd0,
    REG_STOP_DELAY  = 2'd1,
    REG_POWER_STEP  = 2'd2
  } reg_idx_t;

  // Request kinds on the input channel.
  typedef enum logic [1:0] {
    FUNC_TICK        = 2'd0,
    FUNC_LOOP_MODE   = 2'd1,
    FUNC_LOOP_SWITCH = 2'd2,
    FUNC_COLD_SWITCH = 2'd3
  } func_t;

  // Events that reach the controller state machine.
  typedef enum logic [1:0] {
    EV_TIMEOUT  = 2'd0,
    EV_LOOP_ON  = 2'd1,
    EV_LOOP_OFF = 2'd2,
    EV_LEVEL    = 2'd3
  } ev_t;

  // Controller states, one-hot.
  typedef enum logic [3:0] {
    ST_INACTIVE = 4'b0001,
    ST_HIGH     = 4'b0010,
    ST_MEDIUM   = 4'b0100,
    ST_LOW      = 4'b1000
  } fsm_state_t;

  // Reported state codes.
  localparam logic [1:0] PS_INACTIVE = 2'd0;
  localparam logic [1:0] PS_HIGH     = 2'd1;
  localparam logic [1:0] PS_MEDIUM   = 2'd2;
  localparam logic [1:0] PS_LOW      = 2'd3;

  // Configuration register contents.
  typedef struct packed {
    logic [15:0] start_delay_ticks;
    logic [15:0] stop_delay_ticks;
    logic [9:0]  power_step_permil;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic        timer_running;
    logic [1:0]  pump_state;
    logic [9:0]  pump_power;
  } result_t;

  function automatic logic [1:0] state_code(fsm_state_t s);
    logic [1:0] code;
    unique case (s)
      ST_INACTIVE: code = PS_INACTIVE;
      ST_HIGH:     code = PS_HIGH;
      ST_MEDIUM:   code = PS_MEDIUM;
      ST_LOW:      code = PS_LOW;
      default:     code = PS_INACTIVE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

[rtl/core/atppc_cfg.sv]
`default_nettype none

module atppc_cfg
  import atppc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign cfg    = cfg_r;

  // Register write decode; addresses past the list are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_START_DELAY: cfg_nxt.start_delay_ticks = pwdata[15:0];
        REG_STOP_DELAY:  cfg_nxt.stop_delay_ticks  = pwdata[15:0];
        REG_POWER_STEP:  cfg_nxt.power_step_permil = pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_delay_ticks <= START_DELAY_RESET;
      cfg_r.stop_delay_ticks  <= STOP_DELAY_RESET;
      cfg_r.power_step_permil <= STEP_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read data mux.
  always_comb begin
    unique case (idx)
      REG_START_DELAY: prdata = {16'd0, cfg_r.start_delay_ticks};
      REG_STOP_DELAY:  prdata = {16'd0, cfg_r.stop_delay_ticks};
      REG_POWER_STEP:  prdata = {22'd0, cfg_r.power_step_permil};
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/atppc_core.sv]
`default_nettype none

module atppc_core
  import atppc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_en,
  input  wire logic [1:0] func,
  input  wire logic       value,
  input  cfg_t            cfg,
  output result_t         result
);

  // Stored state.
  fsm_state_t st_r;
  logic       last_in_loop_r, loop_sw_r, cold_sw_r;
  logic       came_high_r, came_low_r;
  logic [9:0] adapted_r, step_r, drive_r;
  logic       armed_r;
  logic [15:0] count_r;

  // Working copies, updated in program order.
  fsm_state_t st_nxt, tgt, target;
  logic       last_in_loop_nxt, loop_sw_nxt, cold_sw_nxt;
  logic       came_high_nxt, came_low_nxt;
  logic [9:0] adapted_nxt, step_nxt, drive_nxt;
  logic       armed_nxt;
  logic [15:0] count_nxt;
  logic       ev_vld, old_cold, old_loop;
  ev_t        ev;
  logic [10:0] sum;
  func_t      fn;

  assign fn = func_t'(func);

  always_comb begin
    st_nxt           = st_r;
    last_in_loop_nxt = last_in_loop_r;
    loop_sw_nxt      = loop_sw_r;
    cold_sw_nxt      = cold_sw_r;
    came_high_nxt    = came_high_r;
    came_low_nxt     = came_low_r;
    adapted_nxt      = adapted_r;
    step_nxt         = step_r;
    drive_nxt        = drive_r;
    armed_nxt        = armed_r;
    count_nxt        = count_r;
    ev_vld           = 1'b0;
    ev               = EV_TIMEOUT;
    old_cold         = loop_sw_r | cold_sw_r;
    old_loop         = loop_sw_r;
    sum              = '0;
    target           = st_r;

    // Turn the request into at most one controller event.
    if (step_en) begin
      unique case (fn)
        FUNC_TICK: begin
          if (armed_nxt) begin
            if (count_nxt != 16'd0) count_nxt = count_nxt - 16'd1;
            if (count_nxt == 16'd0) begin
              armed_nxt = 1'b0;
              ev_vld    = 1'b1;
              ev        = EV_TIMEOUT;
            end
          end
        end
        FUNC_LOOP_MODE: begin
          if (value != last_in_loop_nxt) begin
            last_in_loop_nxt = value;
            ev_vld           = 1'b1;
            ev               = value ? EV_LOOP_ON : EV_LOOP_OFF;
          end
        end
        FUNC_LOOP_SWITCH: begin
          if (value != loop_sw_nxt) begin
            loop_sw_nxt = value;
            if ((old_cold != (loop_sw_nxt | cold_sw_nxt)) || (old_loop != loop_sw_nxt)) begin
              ev_vld = 1'b1;
              ev     = EV_LEVEL;
            end
          end
        end
        FUNC_COLD_SWITCH: begin
          if (value != cold_sw_nxt) begin
            cold_sw_nxt = value;
            if ((old_cold != (loop_sw_nxt | cold_sw_nxt)) || (old_loop != loop_sw_nxt)) begin
              ev_vld = 1'b1;
              ev     = EV_LEVEL;
            end
          end
        end
        default: ;
      endcase
    end

    // State the current switch levels call for.
    if (loop_sw_nxt)      tgt = ST_HIGH;
    else if (cold_sw_nxt) tgt = ST_MEDIUM;
    else                  tgt = ST_LOW;

    // Event handling in the current state.
    if (ev_vld) begin
      unique case (st_r)
        ST_INACTIVE: begin
          if (ev == EV_LOOP_ON) target = tgt;
        end
        ST_HIGH: begin
          if (ev == EV_TIMEOUT)       drive_nxt = 10'd0;
          else if (ev == EV_LOOP_OFF) target = ST_INACTIVE;
          else if (ev == EV_LEVEL)    target = tgt;
        end
        ST_MEDIUM: begin
          if (ev == EV_TIMEOUT) begin
            drive_nxt = adapted_nxt;
          end else if (ev == EV_LOOP_OFF) begin
            target = ST_INACTIVE;
          end else if (ev == EV_LEVEL) begin
            // Adapt the medium power on the way up or down.
            if (loop_sw_nxt) begin
              if (came_high_nxt)     step_nxt = cfg.power_step_permil;
              else if (came_low_nxt) step_nxt = step_nxt >> 1;
              adapted_nxt = (adapted_nxt < step_nxt) ? 10'd0 : adapted_nxt - step_nxt;
              target = ST_HIGH;
            end else if (cold_sw_nxt) begin
              target = ST_MEDIUM;
            end else begin
              if (came_high_nxt)     step_nxt = step_nxt >> 1;
              else if (came_low_nxt) step_nxt = cfg.power_step_permil;
              sum = {1'b0, adapted_nxt} + {1'b0, step_nxt};
              adapted_nxt = (sum > {1'b0, POWER_MAX}) ? POWER_MAX : sum[9:0];
              target = ST_LOW;
            end
          end
        end
        default: begin
          if (ev == EV_LOOP_OFF)   target = ST_INACTIVE;
          else if (ev == EV_LEVEL) target = tgt;
        end
      endcase
    end

    // Exit and entry actions on a state change.
    if (target != st_r) begin
      unique case (st_r)
        ST_INACTIVE: begin
          if (!loop_sw_nxt)
            drive_nxt = (loop_sw_nxt | cold_sw_nxt) ? adapted_nxt : POWER_MAX;
        end
        ST_HIGH, ST_MEDIUM: armed_nxt = 1'b0;
        default: ;
      endcase
      unique case (target)
        ST_INACTIVE: drive_nxt = 10'd0;
        ST_HIGH: begin
          came_high_nxt = 1'b1;
          came_low_nxt  = 1'b0;
          if (drive_nxt != 10'd0) begin
            armed_nxt = 1'b1;
            count_nxt = (cfg.stop_delay_ticks == 16'd0) ? 16'd1 : cfg.stop_delay_ticks;
          end
        end
        ST_MEDIUM: begin
          if (came_high_nxt) begin
            armed_nxt = 1'b1;
            count_nxt = (cfg.start_delay_ticks == 16'd0) ? 16'd1 : cfg.start_delay_ticks;
          end else begin
            drive_nxt = adapted_nxt;
          end
        end
        default: begin
          came_high_nxt = 1'b0;
          came_low_nxt  = 1'b1;
          drive_nxt     = POWER_MAX;
        end
      endcase
      st_nxt = target;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r           <= ST_INACTIVE;
      last_in_loop_r <= 1'b0;
      loop_sw_r      <= 1'b0;
      cold_sw_r      <= 1'b0;
      came_high_r    <= 1'b0;
      came_low_r     <= 1'b0;
      adapted_r      <= POWER_MAX;
      step_r         <= STEP_RESET;
      drive_r        <= 10'd0;
      armed_r        <= 1'b0;
      count_r        <= 16'd0;
    end else if (step_en) begin
      st_r           <= st_nxt;
      last_in_loop_r <= last_in_loop_nxt;
      loop_sw_r      <= loop_sw_nxt;
      cold_sw_r      <= cold_sw_nxt;
      came_high_r    <= came_high_nxt;
      came_low_r     <= came_low_nxt;
      adapted_r      <= adapted_nxt;
      step_r         <= step_nxt;
      drive_r        <= drive_nxt;
      armed_r        <= armed_nxt;
      count_r        <= count_nxt;
    end
  end

  // Result reflects the state after this request.
  assign result.pump_power    = drive_nxt;
  assign result.pump_state    = state_code(st_nxt);
  assign result.timer_running = armed_nxt;

endmodule

`default_nettype wire

[rtl/core/adaptive_tank_prime_pump_controller_unit.sv]
// Tank prime pump controller.
// Input channel (in_*): one request per millisecond tick, loop-mode change or
// level-switch change. in_tdata carries the request kind and the new level.
// Output channel (out_*): exactly one result per request, in order, giving
// pump power in per mille, the controller state and the delay-timer flag.
// Configuration (APB): start delay, stop delay and adaptation step at byte
// addresses 0, 4 and 8. Write only while no request is in flight.
// Path: a request accepted into the input register goes through the core when
// the result register is free or being emptied; its result is then captured
// in the result register and presented on the output channel.
// Throughput: one request per cycle while out_tready is high; the state update
// is one pass of logic between the input register and the result register.
// Reset (rst_n low, synchronous): state returns to inactive with power 0,
// registers to their reset values, and both channels are emptied.
// Stall: while out_tready is low the result is held; one further request is
// still taken into the input register, after which in_tready drops.
`default_nettype none

module adaptive_tank_prime_pump_controller_unit
  import atppc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,   // [1:0] func, [2] value
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [15:0]           out_tdata,  // [9:0] pump_power, [11:10] pump_state,
                                                 // [12] timer_running
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  cfg_t       cfg;
  result_t    result;
  logic       s1_valid_r, s1_valid_nxt;
  logic [1:0] s1_func_r;
  logic       s1_value_r;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_data_r;
  logic       adv;
  logic       in_acc;

  atppc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Pipeline control: the input stage advances when the result register is free.
  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_acc ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = adv ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r  <= in_tdata[1:0];
      s1_value_r <= in_tdata[2];
    end
  end

  atppc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (adv),
    .func    (s1_func_r),
    .value   (s1_value_r),
    .cfg     (cfg),
    .result  (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (adv) out_data_r <= result;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_data_r};

endmodule

`default_nettype wire

[rtl/core/atppc_checker.sv]
`default_nettype none
`include "adaptive_tank_prime_pump_controller_unit_defines.svh"

module atppc_checker
  import atppc_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic [7:0]            in_tdata,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [15:0]           out_tdata,
  input wire logic                  psel,
  input wire logic                  penable,
  input wire logic                  pwrite,
  input wire logic [CFG_ADDR_W-1:0] paddr,
  input wire logic [CFG_DATA_W-1:0] pwdata,
  input wire logic [CFG_DATA_W-1:0] prdata,
  input wire logic                  pready
);

  // Power never exceeds the saturation limit.
  `ATPPC_ASSERT_NOW(a_power_max, out_tvalid, out_tdata[9:0] <= POWER_MAX, "pump power above limit")

  // Inactive means no drive and no pending delay.
  `ATPPC_ASSERT_NOW(a_inactive_off, out_tvalid && (out_tdata[11:10] == PS_INACTIVE), (out_tdata[9:0] == 10'd0) && !out_tdata[12], "inactive state with drive or timer")

  // Low level means full drive and no pending delay.
  `ATPPC_ASSERT_NOW(a_low_full, out_tvalid && (out_tdata[11:10] == PS_LOW), (out_tdata[9:0] == POWER_MAX) && !out_tdata[12], "low state without full drive")

  // A stalled result is held.
  `ATPPC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

endmodule

bind adaptive_tank_prime_pump_controller_unit atppc_checker u_atppc_checker (.*);

`default_nettype wire

[dv/adaptive_tank_prime_pump_controller_unit_checker.sv]
`timescale 1ns / 100ps

module adaptive_tank_prime_pump_controller_unit_checker
  import atppc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [1:0] func, [2] value
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [15:0]           out_tdata,  // [9:0] pump_power, [11:10] pump_state,
                                            // [12] timer_running
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic [CFG_DATA_W-1:0] prdata,
  input  logic                  pready,
  output int                    fail_count,
  output int                    pending_count,
  output int                    checked_count
);

  localparam int REPORT_LIMIT = 10;

  // Shadow copy of the configuration registers.
  logic [15:0] cfg_start_delay;
  logic [15:0] cfg_stop_delay;
  logic [9:0]  cfg_step;

  // Predicted controller state.
  logic [1:0]  ctl_state;
  logic        loop_mode;
  logic        loop_sw;
  logic        cold_sw;
  logic        from_high;
  logic        from_low;
  logic [9:0]  adapted_power;
  logic [9:0]  adapt_step;
  logic [9:0]  drive_power;
  logic        delay_armed;
  logic [15:0] delay_count;

  result_t expected_results[$];
  int      fails = 0;
  int      checked = 0;

  initial begin
    fail_count    = 0;
    pending_count = 0;
    checked_count = 0;
  end

  function automatic void flag_error(string what);
    fails++;
    if (fails <= REPORT_LIMIT) begin
      $display("%0t ns: pump checker: %s", $time, what);
    end
  endfunction

  function automatic void reset_model();
    cfg_start_delay = START_DELAY_RESET;
    cfg_stop_delay  = STOP_DELAY_RESET;
    cfg_step        = STEP_RESET;
    ctl_state       = PS_INACTIVE;
    loop_mode       = 1'b0;
    loop_sw         = 1'b0;
    cold_sw         = 1'b0;
    from_high       = 1'b0;
    from_low        = 1'b0;
    adapted_power   = POWER_MAX;
    adapt_step      = STEP_RESET;
    drive_power     = '0;
    delay_armed     = 1'b0;
    delay_count     = '0;
  endfunction

  function automatic void write_register(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_START_DELAY: cfg_start_delay = data[15:0];
      REG_STOP_DELAY:  cfg_stop_delay  = data[15:0];
      REG_POWER_STEP:  cfg_step        = data[9:0];
      default: ;
    endcase
  endfunction

  // The cold level also counts as reached while the loop switch is on.
  function automatic logic cold_level();
    return loop_sw | cold_sw;
  endfunction

  // A delay of zero still takes one tick.
  function automatic void arm_delay(logic [15:0] ticks);
    delay_armed = 1'b1;
    delay_count = (ticks == 16'd0) ? 16'd1 : ticks;
  endfunction

  function automatic logic [1:0] level_target();
    if (loop_sw) return PS_HIGH;
    if (cold_level()) return PS_MEDIUM;
    return PS_LOW;
  endfunction

  function automatic void leave_state(logic [1:0] s);
    case (s)
      PS_INACTIVE: begin
        if (!loop_sw) drive_power = cold_level() ? adapted_power : POWER_MAX;
      end
      PS_HIGH, PS_MEDIUM: delay_armed = 1'b0;
      default: ;
    endcase
  endfunction

  function automatic void enter_state(logic [1:0] s);
    case (s)
      PS_INACTIVE: drive_power = '0;
      PS_HIGH: begin
        from_high = 1'b1;
        from_low  = 1'b0;
        if (drive_power != '0) arm_delay(cfg_stop_delay);
      end
      PS_MEDIUM: begin
        if (from_high) arm_delay(cfg_start_delay);
        else drive_power = adapted_power;
      end
      default: begin
        from_high   = 1'b0;
        from_low    = 1'b1;
        drive_power = POWER_MAX;
      end
    endcase
  endfunction

  // Level change at medium: adapt the medium power, halving the step on a reversal.
  function automatic logic [1:0] medium_move();
    int sum;
    if (loop_sw) begin
      if (from_high) adapt_step = cfg_step;
      else if (from_low) adapt_step = adapt_step >> 1;
      adapted_power = (adapted_power < adapt_step) ? '0 : adapted_power - adapt_step;
      return PS_HIGH;
    end
    if (cold_level()) return PS_MEDIUM;
    if (from_high) adapt_step = adapt_step >> 1;
    else if (from_low) adapt_step = cfg_step;
    sum = int'(adapted_power) + int'(adapt_step);
    adapted_power = (sum > int'(POWER_MAX)) ? POWER_MAX : 10'(sum);
    return PS_LOW;
  endfunction

  function automatic void apply_event(ev_t ev);
    logic [1:0] nxt;
    nxt = ctl_state;
    case (ctl_state)
      PS_INACTIVE: begin
        if (ev == EV_LOOP_ON) nxt = level_target();
      end
      PS_HIGH: begin
        if (ev == EV_TIMEOUT) drive_power = '0;
        else if (ev == EV_LOOP_OFF) nxt = PS_INACTIVE;
        else if (ev == EV_LEVEL) nxt = level_target();
      end
      PS_MEDIUM: begin
        if (ev == EV_TIMEOUT) drive_power = adapted_power;
        else if (ev == EV_LOOP_OFF) nxt = PS_INACTIVE;
        else if (ev == EV_LEVEL) nxt = medium_move();
      end
      default: begin
        if (ev == EV_LOOP_OFF) nxt = PS_INACTIVE;
        else if (ev == EV_LEVEL) nxt = level_target();
      end
    endcase
    if (nxt != ctl_state) begin
      leave_state(ctl_state);
      ctl_state = nxt;
      enter_state(ctl_state);
    end
  endfunction

  // A switch change only matters when one of the effective levels moves.
  function automatic void change_switch(logic is_loop, logic level);
    logic old_cold;
    logic old_loop;
    if ((is_loop ? loop_sw : cold_sw) == level) return;
    old_cold = cold_level();
    old_loop = loop_sw;
    if (is_loop) loop_sw = level;
    else cold_sw = level;
    if (old_cold != cold_level() || old_loop != loop_sw) apply_event(EV_LEVEL);
  endfunction

  function automatic result_t predict_pump(func_t f, logic v);
    result_t r;
    case (f)
      FUNC_TICK: begin
        if (delay_armed) begin
          if (delay_count != '0) delay_count = delay_count - 16'd1;
          if (delay_count == '0) begin
            delay_armed = 1'b0;
            apply_event(EV_TIMEOUT);
          end
        end
      end
      FUNC_LOOP_MODE: begin
        if (v != loop_mode) begin
          loop_mode = v;
          apply_event(v ? EV_LOOP_ON : EV_LOOP_OFF);
        end
      end
      default: change_switch(f == FUNC_LOOP_SWITCH, v);
    endcase
    r.pump_power    = drive_power;
    r.pump_state    = ctl_state;
    r.timer_running = delay_armed;
    return r;
  endfunction

  // Watch both channels and the register port at every edge.
  always @(posedge clk) begin : watch
    result_t               got;
    result_t               want;
    logic [CFG_DATA_W-1:0] want_rd;
    logic [CFG_DATA_W-1:0] rd_mask;
    if (!rst_n) begin
      reset_model();
      expected_results.delete();
    end else begin
      // Register writes and readback.
      if (psel && penable && pready) begin
        if (pwrite) begin
          write_register(reg_idx_t'(paddr[3:2]), pwdata);
        end else begin
          want_rd = '0;
          rd_mask = '0;
          case (reg_idx_t'(paddr[3:2]))
            REG_START_DELAY: begin
              want_rd = CFG_DATA_W'(cfg_start_delay);
              rd_mask = CFG_DATA_W'(16'hFFFF);
            end
            REG_STOP_DELAY: begin
              want_rd = CFG_DATA_W'(cfg_stop_delay);
              rd_mask = CFG_DATA_W'(16'hFFFF);
            end
            REG_POWER_STEP: begin
              want_rd = CFG_DATA_W'(cfg_step);
              rd_mask = CFG_DATA_W'(10'h3FF);
            end
            default: ;
          endcase
          if ((prdata & rd_mask) != want_rd) begin
            flag_error($sformatf("readback at address %0d: expected %0d, got %0d",
                                 paddr, want_rd, prdata & rd_mask));
          end
        end
      end

      // Each accepted request yields exactly one expected result.
      if (in_tvalid && in_tready) begin
        expected_results.push_back(predict_pump(func_t'(in_tdata[1:0]), in_tdata[2]));
      end

      // Compare each result with the oldest expectation.
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[12:0]);
        if (expected_results.size() == 0) begin
          flag_error($sformatf("unexpected result: power %0d state %0d timer %0b",
                               got.pump_power, got.pump_state, got.timer_running));
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (got.pump_power != want.pump_power || got.pump_state != want.pump_state ||
              got.timer_running != want.timer_running) begin
            flag_error($sformatf(
              "result %0d: expected power %0d state %0d timer %0b, got power %0d state %0d timer %0b",
              checked, want.pump_power, want.pump_state, want.timer_running,
              got.pump_power, got.pump_state, got.timer_running));
          end
        end
      end
    end
    fail_count    <= fails;
    pending_count <= expected_results.size();
    checked_count <= checked;
  end

endmodule

[dv/adaptive_tank_prime_pump_controller_unit_tb.sv]
`timescale 1ns / 100ps

module adaptive_tank_prime_pump_controller_unit_tb;
  import atppc_pkg::*;

  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 200;
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_LIMIT    = 3000;
  localparam int SETTLE_CYCLES = 8;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;   // [1:0] func, [2] value
  logic                  out_tvalid;
  logic                  out_tready;
  logic [15:0]           out_tdata;  // [9:0] pump_power, [11:10] pump_state,
                                     // [12] timer_running
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int fail_count;
  int pending_count;
  int checked_count;
  int idle_cycles = 0;
  int sent_count = 0;
  int reg_accesses = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  adaptive_tank_prime_pump_controller_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  adaptive_tank_prime_pump_controller_unit_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(12, 50);
  endfunction

  function automatic func_t pick_func();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return FUNC_TICK;
    if (r < 52) return FUNC_LOOP_MODE;
    if (r < 76) return FUNC_LOOP_SWITCH;
    return FUNC_COLD_SWITCH;
  endfunction

  // Offer one request after an optional gap and wait until it is taken.
  task automatic send_request(func_t f, logic v, int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, v, f};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_count++;
  endtask

  // Stop offering and wait until every expected result has come out.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register, then read it back.
  task automatic access_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    reg_accesses++;
  endtask

  task automatic configure(logic [15:0] start_d, logic [15:0] stop_d, logic [9:0] step);
    access_reg(REG_START_DELAY, CFG_DATA_W'(start_d));
    access_reg(REG_STOP_DELAY, CFG_DATA_W'(stop_d));
    access_reg(REG_POWER_STEP, CFG_DATA_W'(step));
  endtask

  // Result side: random ready pattern, plus one long hold-off on request.
  initial begin : receiver
    int gap;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("adaptive_tank_prime_pump_controller_unit_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    func_t f;
    logic  v;
    int    gap;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk through the states at reset settings.
    send_request(FUNC_TICK, 1'b1, 0);         // tick while inactive is ignored
    send_request(FUNC_COLD_SWITCH, 1'b1, 0);  // level change while inactive
    send_request(FUNC_COLD_SWITCH, 1'b1, 1);  // repeated switch level
    send_request(FUNC_LOOP_MODE, 1'b0, 0);    // repeated loop-mode flag
    send_request(FUNC_LOOP_MODE, 1'b1, 0);    // start at medium
    send_request(FUNC_LOOP_SWITCH, 1'b1, 0);  // medium to high, stop delay armed
    send_request(FUNC_TICK, 1'b0, 0);         // zero stop delay fires on first tick
    send_request(FUNC_COLD_SWITCH, 1'b0, 0);  // no effective level change
    send_request(FUNC_LOOP_SWITCH, 1'b0, 2);  // high to low
    send_request(FUNC_COLD_SWITCH, 1'b1, 0);  // low to medium
    send_request(FUNC_COLD_SWITCH, 1'b0, 0);  // medium to low, step reloads
    send_request(FUNC_COLD_SWITCH, 1'b1, 0);
    send_request(FUNC_LOOP_SWITCH, 1'b1, 0);  // reversal halves the step
    send_request(FUNC_LOOP_SWITCH, 1'b0, 0);  // high to medium, start delay armed
    send_request(FUNC_TICK, 1'b1, 0);
    send_request(FUNC_LOOP_SWITCH, 1'b1, 0);  // medium to high while the timer runs
    send_request(FUNC_LOOP_MODE, 1'b0, 0);    // loop mode off goes inactive
    send_request(FUNC_LOOP_MODE, 1'b1, 3);    // inactive straight to high, no power
    send_request(FUNC_LOOP_SWITCH, 1'b0, 0);  // high to medium, start delay armed
    send_request(FUNC_LOOP_MODE, 1'b0, 0);    // medium to inactive drops the timer
    send_request(FUNC_COLD_SWITCH, 1'b0, 0);
    send_request(FUNC_LOOP_MODE, 1'b1, 0);    // inactive to low at full power
    send_request(FUNC_TICK, 1'b0, 0);
    drain();

    // Random phases, each under its own register setting.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: configure(16'd0, 16'd0, POWER_MAX);
        1: configure(16'd1, 16'd2, 10'd1);
        2: configure(16'hFFFF, 16'hFFFF, 10'h3FF);
        3: configure(START_DELAY_RESET, STOP_DELAY_RESET, STEP_RESET);
        4: configure(16'd60000, 16'd0, 10'd0);
        default: configure(16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                           10'($urandom_range(0, 600)));
      endcase
      // Hold the result side off for a while so the block backs up.
      if (phase == 1) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        f = pick_func();
        if (f == FUNC_LOOP_MODE) v = ($urandom_range(0, 99) < 85);
        else v = 1'($urandom_range(0, 1));
        gap = (hold_req && !hold_done) ? 0 : pick_gap();
        send_request(f, v, gap);
      end
      drain();
    end

    $display("summary: %0d requests sent, %0d results checked, %0d register accesses",
             sent_count, checked_count, reg_accesses);
    $display("summary: delays and step from zero to full width, one long result stall");
    if (fail_count == 0) begin
      $display("adaptive_tank_prime_pump_controller_unit_tb: done, clean");
    end else begin
      $display("adaptive_tank_prime_pump_controller_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/atppc_pkg.sv
rtl/core/atppc_cfg.sv
rtl/core/atppc_core.sv
rtl/core/adaptive_tank_prime_pump_controller_unit.sv
rtl/core/atppc_checker.sv
dv/adaptive_tank_prime_pump_controller_unit_checker.sv
dv/adaptive_tank_prime_pump_controller_unit_tb.sv
